@@ rtl/gvi_pkg.sv @@
`default_nettype none
package gvi_pkg;

    localparam int unsigned DIV_STEPS  = 31;
    localparam int unsigned SQRT_STEPS = 32;

    typedef enum logic [1:0] {
        ITER_DIV  = 2'b01,
        ITER_SQRT = 2'b10
    } t_iter_op;

    typedef struct packed {
        logic        start;
        t_iter_op    op;
        logic [63:0] rem;
        logic [62:0] dvsr;
        logic [63:0] src;
    } t_iter_req;

    typedef struct packed {
        logic        busy;
        logic [31:0] q;
    } t_iter_rsp;

endpackage
`default_nettype wire

@@ rtl/gravity_velocity_integrator.sv @@
`default_nettype none
// Channel  Direction  Handshake              Payload
// s        in         i_s_tvalid/o_s_tready  i_s_tdata, i_s_tuser (mode)
// m        out        o_m_tvalid/i_m_tready  o_m_tdata, o_m_tuser (flags)
// apb      in         psel/penable/pready    paddr, pwdata, prdata
// Modes 0, 2 and 3 run on the shared multiplier.
// A planet uses the shared iterative unit for the square root and up to three long
// divisions (two with its pull capped); a skip does not use the iterative unit.
// Reset is synchronous and clears velocity, owner position, dt and thrust.
// A finished result waits in the output register; the next transaction is
// taken meanwhile, and the result after it waits until that one is taken.
module gravity_velocity_integrator
    import gvi_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    // dt, dir_x, dir_y, dir_z, pos_x, pos_y, planet_mass, reach, speed, pad
    input  wire logic [215:0] i_s_tdata,
    // mode
    input  wire logic [1:0]   i_s_tuser,
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    // vel_x, vel_y, vel_z, move_x, move_y, move_z
    output logic [191:0]      o_m_tdata,
    // moved, applied
    output logic [1:0]        o_m_tuser,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_PLANET = 2'd1,
        MODE_SPEED  = 2'd2,
        MODE_REPORT = 2'd3
    } t_mode;

    typedef enum logic [19:0] {
        S_IDLE  = 20'h00001,
        S_TD    = 20'h00002,
        S_TD2   = 20'h00004,
        S_CMUL  = 20'h00008,
        S_CACC  = 20'h00010,
        S_PDIFF = 20'h00020,
        S_PFAR  = 20'h00040,
        S_PSQX  = 20'h00080,
        S_PSQY  = 20'h00100,
        S_PCMP  = 20'h00200,
        S_PG1   = 20'h00400,
        S_PG2   = 20'h00800,
        S_PG3   = 20'h01000,
        S_PSQW  = 20'h02000,
        S_PADIV = 20'h04000,
        S_PADW  = 20'h08000,
        S_PPM   = 20'h10000,
        S_PPD   = 20'h20000,
        S_PPW   = 20'h40000,
        S_OUT   = 20'h80000
    } t_state;

    localparam logic [2:0]          ADDR_THRUST = 3'd0;
    localparam logic [24:0]         GRAV_G      = 25'd20000000;
    localparam logic [62:0]         MIN_R2      = 63'd429496730;
    localparam logic [30:0]         AD_CAP      = 31'h7FFFFFFF;
    localparam logic signed [34:0]  SAT_HI      = 35'sd2147483647;
    localparam logic signed [34:0]  SAT_LO      = -35'sd2147483648;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] v,
                                                   input logic signed [33:0] a);
        logic signed [34:0] s;
        s = {{3{v[31]}}, v} + {a[33], a};
        if (s > SAT_HI) begin
            return 32'sh7FFFFFFF;
        end else if (s < SAT_LO) begin
            return 32'sh80000000;
        end
        return s[31:0];
    endfunction

    t_state r_state, n_state;
    t_mode  r_mode;
    logic [1:0] r_k;

    logic signed [31:0] r_thrust;
    logic signed [31:0] r_vel [3];
    logic signed [31:0] r_owner_x, r_owner_y;
    logic [15:0]        r_tick_dt;

    logic [15:0]        r_dt_in;
    logic signed [15:0] r_dir [3];
    logic signed [31:0] r_px, r_py, r_speed;
    logic [23:0]        r_mass;
    logic [30:0]        r_reach;

    logic signed [31:0] r_d;
    logic signed [31:0] r_mv [3];
    logic               r_applied;
    logic signed [32:0] r_dx, r_dy;
    logic [62:0]        r_r2;
    logic [19:0]        r_md_hi;
    logic [64:0]        r_p;
    logic [31:0]        r_r;
    logic [30:0]        r_ad;

    logic signed [32:0] ma, mb;
    logic signed [65:0] r_prod;

    logic               r_ovalid;
    logic [191:0]       r_odata;
    logic [1:0]         r_ouser;

    t_iter_req          iter_req;
    t_iter_rsp          iter_rsp;

    logic               s_accept;
    logic               out_free;
    logic [32:0]        adx, ady, adk;
    logic signed [33:0] pull;

    assign s_accept = i_s_tvalid && o_s_tready;
    assign out_free = !r_ovalid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE);

    assign adx  = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign ady  = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    assign adk  = (r_k == 2'd0) ? adx : ady;
    assign pull = ((r_k == 2'd0) ? r_dx[32] : r_dy[32])
                ? -$signed({3'b000, iter_rsp.q[30:0]})
                :  $signed({3'b000, iter_rsp.q[30:0]});

    always_comb begin
        ma = '0;
        mb = '0;
        unique case (r_state)
            S_TD: begin
                ma = {r_thrust[31], r_thrust};
                mb = {17'd0, r_dt_in};
            end
            S_CMUL: begin
                unique case (r_mode)
                    MODE_TICK:   ma = {r_d[31], r_d};
                    MODE_SPEED:  ma = {r_speed[31], r_speed};
                    MODE_REPORT: ma = {r_vel[r_k][31], r_vel[r_k]};
                    MODE_PLANET: ma = '0;
                endcase
                mb = (r_mode == MODE_REPORT) ? $signed({17'd0, r_tick_dt})
                                             : $signed({{17{r_dir[r_k][15]}}, r_dir[r_k]});
            end
            S_PFAR: begin
                ma = $signed(adx);
                mb = $signed(adx);
            end
            S_PSQX: begin
                ma = $signed(ady);
                mb = $signed(ady);
            end
            S_PSQY: begin
                ma = {2'b00, r_reach};
                mb = {2'b00, r_reach};
            end
            S_PCMP: begin
                ma = {9'd0, r_mass};
                mb = {17'd0, r_tick_dt};
            end
            S_PG1: begin
                ma = {13'd0, r_prod[19:0]};
                mb = {8'd0, GRAV_G};
            end
            S_PG2: begin
                ma = {13'd0, r_md_hi};
                mb = {8'd0, GRAV_G};
            end
            S_PPM: begin
                ma = {2'b00, r_ad};
                mb = $signed(adk);
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= ma * mb;
    end

    always_comb begin
        iter_req = '0;
        iter_req.op = ITER_DIV;
        unique case (r_state)
            S_PCMP: begin
                iter_req.start = !((r_r2 < MIN_R2) || (r_r2 > r_prod[62:0]));
                iter_req.op    = ITER_SQRT;
                iter_req.src   = {1'b0, r_r2};
            end
            S_PADIV: begin
                iter_req.start = ({r_p, 1'b0} < {3'b000, r_r2});
                iter_req.rem   = {r_p[62:0], 1'b0};
                iter_req.dvsr  = r_r2;
            end
            S_PPD: begin
                iter_req.start = 1'b1;
                iter_req.rem   = {33'd0, r_prod[61:31]};
                iter_req.dvsr  = {31'd0, r_r};
                iter_req.src   = {r_prod[30:0], 33'd0};
            end
            default: begin
                iter_req.start = 1'b0;
            end
        endcase
    end

    gvi_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (iter_req),
        .o_rsp   (iter_rsp)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    unique case (t_mode'(i_s_tuser))
                        MODE_TICK:   n_state = S_TD;
                        MODE_PLANET: n_state = S_PDIFF;
                        MODE_SPEED:  n_state = S_CMUL;
                        MODE_REPORT: n_state = S_CMUL;
                    endcase
                end
            end
            S_TD:    n_state = S_TD2;
            S_TD2:   n_state = S_CMUL;
            S_CMUL:  n_state = S_CACC;
            S_CACC:  n_state = (r_k == 2'd2) ? S_OUT : S_CMUL;
            S_PDIFF: n_state = S_PFAR;
            S_PFAR: begin
                n_state = ((adx > {2'b00, r_reach}) || (ady > {2'b00, r_reach}))
                        ? S_OUT : S_PSQX;
            end
            S_PSQX:  n_state = S_PSQY;
            S_PSQY:  n_state = S_PCMP;
            S_PCMP:  n_state = iter_req.start ? S_PG1 : S_OUT;
            S_PG1:   n_state = S_PG2;
            S_PG2:   n_state = S_PG3;
            S_PG3:   n_state = S_PSQW;
            S_PSQW:  n_state = iter_rsp.busy ? S_PSQW : S_PADIV;
            S_PADIV: n_state = iter_req.start ? S_PADW : S_PPM;
            S_PADW:  n_state = iter_rsp.busy ? S_PADW : S_PPM;
            S_PPM:   n_state = S_PPD;
            S_PPD:   n_state = S_PPW;
            S_PPW: begin
                if (!iter_rsp.busy) begin
                    n_state = (r_k == 2'd1) ? S_OUT : S_PPM;
                end
            end
            S_OUT:   n_state = out_free ? S_IDLE : S_OUT;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_thrust  <= '0;
            r_vel[0]  <= '0;
            r_vel[1]  <= '0;
            r_vel[2]  <= '0;
            r_owner_x <= '0;
            r_owner_y <= '0;
            r_tick_dt <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (psel && penable && pwrite && pready && (paddr == ADDR_THRUST)) begin
                r_thrust <= pwdata;
            end
            if (r_state == S_TD2) begin
                r_tick_dt <= r_dt_in;
                r_owner_x <= r_px;
                r_owner_y <= r_py;
            end
            if (r_state == S_CACC) begin
                if (r_mode == MODE_TICK) begin
                    r_vel[r_k] <= sat_add(r_vel[r_k], r_prod[47:14]);
                end else if (r_mode == MODE_SPEED) begin
                    r_vel[r_k] <= sat_add(32'sd0, r_prod[47:14]);
                end
            end
            if ((r_state == S_PPW) && !iter_rsp.busy) begin
                r_vel[r_k] <= sat_add(r_vel[r_k], pull);
            end
            if ((r_state == S_OUT) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_mode    <= t_mode'(i_s_tuser);
            r_dt_in   <= i_s_tdata[15:0];
            r_dir[0]  <= i_s_tdata[31:16];
            r_dir[1]  <= i_s_tdata[47:32];
            r_dir[2]  <= i_s_tdata[63:48];
            r_px      <= i_s_tdata[95:64];
            r_py      <= i_s_tdata[127:96];
            r_mass    <= i_s_tdata[151:128];
            r_reach   <= i_s_tdata[182:152];
            r_speed   <= i_s_tdata[214:183];
            r_k       <= 2'd0;
            r_applied <= 1'b0;
            r_mv[0]   <= '0;
            r_mv[1]   <= '0;
            r_mv[2]   <= '0;
        end
        unique case (r_state)
            S_TD2:   r_d <= r_prod[47:16];
            S_CACC: begin
                if (r_mode == MODE_REPORT) begin
                    r_mv[r_k] <= r_prod[47:16];
                end
                r_k <= r_k + 2'd1;
            end
            S_PDIFF: begin
                r_dx <= {r_px[31], r_px} - {r_owner_x[31], r_owner_x};
                r_dy <= {r_py[31], r_py} - {r_owner_y[31], r_owner_y};
            end
            S_PSQX:  r_r2 <= r_prod[62:0];
            S_PSQY:  r_r2 <= r_r2 + r_prod[62:0];
            S_PG1:   r_md_hi <= r_prod[39:20];
            S_PG2:   r_p <= {20'd0, r_prod[44:0]};
            S_PG3:   r_p <= r_p + {r_prod[44:0], 20'd0};
            S_PSQW:  r_r <= iter_rsp.q;
            S_PADIV: begin
                if (!iter_req.start) begin
                    r_ad <= AD_CAP;
                end
            end
            S_PADW:  r_ad <= iter_rsp.q[30:0];
            S_PPW: begin
                if (!iter_rsp.busy) begin
                    r_k <= r_k + 2'd1;
                    if (r_k == 2'd1) begin
                        r_applied <= 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
        if ((r_state == S_OUT) && out_free) begin
            r_odata <= {r_mv[2], r_mv[1], r_mv[0], r_vel[2], r_vel[1], r_vel[0]};
            r_ouser <= {r_applied, (r_mv[0] != 0) || (r_mv[1] != 0) || (r_mv[2] != 0)};
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ouser;
    assign prdata     = (paddr == ADDR_THRUST) ? r_thrust : 32'd0;
    assign pready     = 1'b1;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> !o_s_tready)
        else $error("transaction accepted while block still busy");
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[0] && o_m_tuser[1]))
        else $error("moved and applied both set");
    a_moved_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0]) |-> (o_m_tdata[191:96] != 96'd0))
        else $error("moved set with zero movement");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && !out_free) |=> (r_state == S_OUT))
        else $error("result lost while output stalled");
`endif

endmodule
`default_nettype wire

@@ rtl/gvi_iter.sv @@
`default_nettype none
module gvi_iter
    import gvi_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_iter_req i_req,
    output t_iter_rsp      o_rsp
);

    logic        r_busy;
    t_iter_op    r_op;
    logic [5:0]  r_cnt;
    logic [63:0] r_rem;
    logic [62:0] r_dvsr;
    logic [63:0] r_src;
    logic [31:0] r_q;

    logic [63:0] cand;
    logic [63:0] sub;
    logic        ge;

    always_comb begin
        unique case (r_op)
            ITER_DIV: begin
                cand = {r_rem[62:0], r_src[63]};
                sub  = {1'b0, r_dvsr};
            end
            ITER_SQRT: begin
                cand = {r_rem[61:0], r_src[63:62]};
                sub  = {30'd0, r_q, 2'b01};
            end
            default: begin
                cand = r_rem;
                sub  = 64'd0;
            end
        endcase
        ge = (cand >= sub);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_op   <= ITER_DIV;
            r_cnt  <= 6'd0;
        end else if (i_req.start && !r_busy) begin
            r_busy <= 1'b1;
            r_op   <= i_req.op;
            r_cnt  <= (i_req.op == ITER_SQRT) ? 6'(SQRT_STEPS - 1) : 6'(DIV_STEPS - 1);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 6'd1;
            if (r_cnt == 6'd0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem  <= i_req.rem;
            r_dvsr <= i_req.dvsr;
            r_src  <= i_req.src;
            r_q    <= 32'd0;
        end else if (r_busy) begin
            r_rem <= ge ? (cand - sub) : cand;
            r_q   <= {r_q[30:0], ge};
            r_src <= (r_op == ITER_SQRT) ? {r_src[61:0], 2'b00} : {r_src[62:0], 1'b0};
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.q    = r_q;

`ifndef SYNTHESIS
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("iteration started while busy");
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.start && !r_busy) |=> r_busy)
        else $error("iteration did not start");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt < 6'(SQRT_STEPS)))
        else $error("step count out of range");
`endif

endmodule
`default_nettype wire
